// ===== rtl/tdpl_pkg.sv =====
package tdpl_pkg;

  localparam int unsigned ValW        = 9;
  localparam int unsigned MaxBound    = 311;
  localparam int unsigned ResultLimit = 64;
  localparam int unsigned CntW        = $clog2(ResultLimit + 1);
  localparam int unsigned BitsPerStep = 3;
  localparam int unsigned DivSteps    = (ValW + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned StepW       = $clog2(DivSteps);

  typedef struct packed {
    logic load;
    logic start_cand;
    logic start_div;
    logic next_div;
    logic next_cand;
    logic take;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cand_gt_bound;
    logic div_ge_cand;
    logic rem_done;
    logic rem_zero;
    logic will_fill;
  } status_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic digits_t to_digits(logic [ValW-1:0] v);
    digits_t        d;
    logic [ValW-1:0] r;
    logic [6:0]     r7;
    logic [14:0]    p;
    logic [6:0]     t10;
    if (v >= ValW'(300)) begin
      d.hundreds = 2'd3;
      r = v - ValW'(300);
    end else if (v >= ValW'(200)) begin
      d.hundreds = 2'd2;
      r = v - ValW'(200);
    end else if (v >= ValW'(100)) begin
      d.hundreds = 2'd1;
      r = v - ValW'(100);
    end else begin
      d.hundreds = 2'd0;
      r = v;
    end
    r7 = r[6:0];
    p = 15'(r7) * 15'd205;
    d.tens = p[14:11];
    t10 = 7'(d.tens) * 7'd10;
    d.ones = 4'(r7 - t10);
    return d;
  endfunction

endpackage

// ===== rtl/tdpl_rem.sv =====
module tdpl_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tdpl_pkg::ValW-1:0]   dividend_i,
  input  logic [tdpl_pkg::ValW-1:0]   divisor_i,
  output logic                        done_o,
  output logic                        zero_o
);

  logic [tdpl_pkg::ValW-1:0]  dvd_q, dvd_d;
  logic [tdpl_pkg::ValW-1:0]  dsr_q;
  logic [tdpl_pkg::ValW-1:0]  rem_q, rem_d;
  logic [tdpl_pkg::StepW-1:0] step_q;
  logic                       run_q;
  logic                       done_q;

  always_comb begin
    logic [tdpl_pkg::ValW:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int i = 0; i < tdpl_pkg::BitsPerStep; i++) begin
      t = {rem_d, dvd_d[tdpl_pkg::ValW-1]};
      dvd_d = {dvd_d[tdpl_pkg::ValW-2:0], 1'b0};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      rem_d = t[tdpl_pkg::ValW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == tdpl_pkg::StepW'(tdpl_pkg::DivSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

// ===== rtl/tdpl_dp.sv =====
module tdpl_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tdpl_pkg::cmd_t            cmd_i,
  output tdpl_pkg::status_t         status_o,
  input  logic [tdpl_pkg::ValW-1:0] upper_bound_i,
  output logic                      result_valid_o,
  output logic [tdpl_pkg::ValW-1:0] prime_value_o,
  output logic [1:0]                digit_hundreds_o,
  output logic [3:0]                digit_tens_o,
  output logic [3:0]                digit_ones_o,
  output logic                      last_prime_o
);

  logic [tdpl_pkg::ValW-1:0] bound_q;
  logic [tdpl_pkg::ValW-1:0] cand_q;
  logic [tdpl_pkg::ValW-1:0] div_q;
  logic [tdpl_pkg::ValW-1:0] pend_q;
  logic                      pend_valid_q;
  logic [tdpl_pkg::CntW-1:0] count_q;
  logic                      valid_q;
  logic [tdpl_pkg::ValW-1:0] value_q;
  tdpl_pkg::digits_t         digits_q;
  tdpl_pkg::digits_t         pend_digits;
  logic                      last_q;
  logic                      rem_done;
  logic                      rem_zero;
  logic                      emit;

  tdpl_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  assign pend_digits = tdpl_pkg::to_digits(pend_q);
  assign emit        = (cmd_i.take || cmd_i.finish) && pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= emit;
      if (cmd_i.load) begin
        pend_valid_q <= 1'b0;
        count_q      <= '0;
      end else if (cmd_i.take) begin
        pend_valid_q <= 1'b1;
        count_q      <= count_q + 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (upper_bound_i > tdpl_pkg::ValW'(tdpl_pkg::MaxBound)) begin
        bound_q <= tdpl_pkg::ValW'(tdpl_pkg::MaxBound);
      end else begin
        bound_q <= upper_bound_i;
      end
      cand_q <= tdpl_pkg::ValW'(2);
    end else if (cmd_i.next_cand || cmd_i.take) begin
      cand_q <= cand_q + 1'b1;
    end
    if (cmd_i.start_cand) begin
      div_q <= tdpl_pkg::ValW'(2);
    end else if (cmd_i.next_div) begin
      div_q <= div_q + 1'b1;
    end
    if (cmd_i.take) begin
      pend_q <= cand_q;
    end
    if (emit) begin
      value_q  <= pend_q;
      digits_q <= pend_digits;
      last_q   <= cmd_i.finish;
    end
  end

  assign status_o.cand_gt_bound = (cand_q > bound_q);
  assign status_o.div_ge_cand   = (div_q >= cand_q);
  assign status_o.rem_done      = rem_done;
  assign status_o.rem_zero      = rem_zero;
  assign status_o.will_fill     = (count_q == tdpl_pkg::CntW'(tdpl_pkg::ResultLimit - 1));

  assign result_valid_o   = valid_q;
  assign prime_value_o    = value_q;
  assign digit_hundreds_o = digits_q.hundreds;
  assign digit_tens_o     = digits_q.tens;
  assign digit_ones_o     = digits_q.ones;
  assign last_prime_o     = last_q;

endmodule

// ===== rtl/tdpl_ctrl.sv =====
module tdpl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tdpl_pkg::status_t    status_i,
  output tdpl_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCand,
    StTest,
    StWait,
    StFlush
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StCand;
        end
      end
      StCand: begin
        if (status_i.cand_gt_bound) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.start_cand = 1'b1;
          state_d          = StTest;
        end
      end
      StTest: begin
        if (status_i.div_ge_cand) begin
          cmd_o.take = 1'b1;
          state_d    = status_i.will_fill ? StFlush : StCand;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = StWait;
        end
      end
      StWait: begin
        if (status_i.rem_done) begin
          if (status_i.rem_zero) begin
            cmd_o.next_cand = 1'b1;
            state_d         = StCand;
          end else begin
            cmd_o.next_div = 1'b1;
            state_d        = StTest;
          end
        end
      end
      StFlush: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != StIdle);
    end
  end

  assign busy = busy_q;

endmodule

// ===== rtl/trial_division_prime_lister_unit.sv =====
// Lists every prime from 2 up to the requested bound (saturated at 311) in ascending order,
// one result per clock strobe on result_valid_o, with its decimal digits; the final result of
// a request has last_prime_o set, and a bound below two yields no result. A request is taken
// when start is high and busy is low, and busy stays high until the last result has been
// issued. Each trial divisor passes through the three-bits-per-cycle remainder unit and
// its controller loop. The receiver cannot stall the block: each result is present for
// exactly one cycle and must be captured then.
module trial_division_prime_lister_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [tdpl_pkg::ValW-1:0] upper_bound_i,
  output logic                      result_valid_o,
  output logic [tdpl_pkg::ValW-1:0] prime_value_o,
  output logic [1:0]                digit_hundreds_o,
  output logic [3:0]                digit_tens_o,
  output logic [3:0]                digit_ones_o,
  output logic                      last_prime_o
);

  tdpl_pkg::cmd_t    cmd;
  tdpl_pkg::status_t status;

  tdpl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tdpl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .upper_bound_i    (upper_bound_i),
    .result_valid_o   (result_valid_o),
    .prime_value_o    (prime_value_o),
    .digit_hundreds_o (digit_hundreds_o),
    .digit_tens_o     (digit_tens_o),
    .digit_ones_o     (digit_ones_o),
    .last_prime_o     (last_prime_o)
  );

endmodule

// ===== dv/trial_division_prime_lister_unit_tb.sv =====
`timescale 1ns / 1ps

module trial_division_prime_lister_unit_tb;
  import tdpl_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [ValW-1:0] value;
    digits_t         digits;
    logic            last;
  } prime_rec_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [ValW-1:0] upper_bound_i;
  logic            result_valid_o;
  logic [ValW-1:0] prime_value_o;
  logic [1:0]      digit_hundreds_o;
  logic [3:0]      digit_tens_o;
  logic [3:0]      digit_ones_o;
  logic            last_prime_o;

  prime_rec_t  prime_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;

  trial_division_prime_lister_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .upper_bound_i    (upper_bound_i),
    .result_valid_o   (result_valid_o),
    .prime_value_o    (prime_value_o),
    .digit_hundreds_o (digit_hundreds_o),
    .digit_tens_o     (digit_tens_o),
    .digit_ones_o     (digit_ones_o),
    .last_prime_o     (last_prime_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit has_no_divisor(int unsigned cand);
    for (int unsigned d = 2; d < cand; d++) begin
      if (cand % d == 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_primes(logic [ValW-1:0] bound_raw);
    int unsigned bound;
    int unsigned count;
    prime_rec_t  rec;
    bound = 32'(bound_raw);
    count = 0;
    if (bound > MaxBound) begin
      bound = MaxBound;
    end
    for (int unsigned cand = 2; cand <= bound && count < ResultLimit; cand++) begin
      if (has_no_divisor(cand)) begin
        rec.value           = ValW'(cand);
        rec.digits.hundreds = 2'(cand / 100);
        rec.digits.tens     = 4'((cand / 10) % 10);
        rec.digits.ones     = 4'(cand % 10);
        rec.last            = 1'b0;
        prime_q.push_back(rec);
        count++;
      end
    end
    if (count > 0) begin
      prime_q[prime_q.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic note_error(string what, prime_rec_t exp_rec, prime_rec_t got_rec);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s: expected %0d (%0d %0d %0d) last %0b, got %0d (%0d %0d %0d) last %0b",
               $realtime, what, exp_rec.value, exp_rec.digits.hundreds, exp_rec.digits.tens,
               exp_rec.digits.ones, exp_rec.last, got_rec.value, got_rec.digits.hundreds,
               got_rec.digits.tens, got_rec.digits.ones, got_rec.last);
    end
  endtask

  always @(posedge clk_i) begin
    prime_rec_t got_rec;
    prime_rec_t exp_rec;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got_rec.value           = prime_value_o;
      got_rec.digits.hundreds = digit_hundreds_o;
      got_rec.digits.tens     = digit_tens_o;
      got_rec.digits.ones     = digit_ones_o;
      got_rec.last            = last_prime_o;
      if (prime_q.size() == 0) begin
        note_error("unexpected result", '0, got_rec);
      end else begin
        exp_rec = prime_q.pop_front();
        if (got_rec.value !== exp_rec.value ||
            got_rec.digits.hundreds !== exp_rec.digits.hundreds ||
            got_rec.digits.tens !== exp_rec.digits.tens ||
            got_rec.digits.ones !== exp_rec.digits.ones ||
            got_rec.last !== exp_rec.last) begin
          note_error("mismatch", exp_rec, got_rec);
        end
      end
    end
  end

  initial begin
    while (idle_cnt < IdleLimit) begin
      @(posedge clk_i);
      if (result_valid_o === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
    end
    $display("%0t: no request or result for %0d cycles", $realtime, IdleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(30, 300);
  endfunction

  // Start stays high between back-to-back requests and is lowered only for a gap or by wait_drained.
  task automatic send_request(logic [ValW-1:0] bound, int unsigned gap);
    if (gap > 0) begin
      start = 1'b0;
      upper_bound_i = ValW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    upper_bound_i = bound;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    predict_primes(bound);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (prime_q.size() != 0 || busy !== 1'b0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic test_small_bounds();
    int unsigned bounds[10] = '{0, 1, 2, 3, 4, 5, 7, 8, 10, 11};
    foreach (bounds[i]) begin
      send_request(ValW'(bounds[i]), pick_gap());
    end
  endtask

  task automatic test_decade_bounds();
    send_request(ValW'(97), 0);
    send_request(ValW'(100), 0);
    send_request(ValW'(101), pick_gap());
  endtask

  task automatic test_top_bounds();
    send_request(ValW'(256), pick_gap());
    send_request(ValW'(MaxBound), 0);
    send_request(ValW'(MaxBound + 1), pick_gap());
    send_request('1, 0);
  endtask

  task automatic test_pause_until_drained();
    send_request(ValW'($urandom_range(20, 60)), 0);
    send_request(ValW'($urandom_range(0, 1)), 0);
    wait_drained();
    send_request(ValW'($urandom_range(2, 40)), 0);
    wait_drained();
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned roll;
    logic [ValW-1:0] bound;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        bound = ValW'($urandom_range(0, 1));
      end else if (roll < 80) begin
        bound = ValW'($urandom_range(2, 63));
      end else begin
        bound = ValW'($urandom_range(64, 160));
      end
      send_request(bound, pick_gap());
    end
  endtask

  task automatic test_random_large(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_request(ValW'($urandom_range(150, 511)), pick_gap());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    upper_bound_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_small_bounds();
    test_decade_bounds();
    test_top_bounds();
    test_pause_until_drained();
    test_random_mix(92);
    test_random_large(3);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (err_cnt == 0 && prime_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
